### src/lru_page_replacement_defines.svh
// assertion macros for the lru page replacement block
// used by the front and back modules; no other dependencies
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LRU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lru assertion failed");
`define LRU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lru assertion failed");
`else
`define LRU_ASSERT(lbl, clk, rst, prop)
`define LRU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### src/lru_pkg.sv
// shared constants and payload types for the lru page replacement block
// no dependencies
`default_nettype none

package lru_pkg;

   localparam int MAX_FRAMES_DEF = 8;
   localparam int PAGE_BITS      = 16;
   localparam int COUNT_BITS     = 32;
   localparam int CSR_BITS       = 4;
   localparam int QUEUE_DEPTH    = 2;
   localparam logic [CSR_BITS-1:0] FRAMES_RESET = 4'd8;

   typedef struct packed {
      logic [PAGE_BITS-1:0] page_number;
      logic                 restart;
   } req_type;

   typedef struct packed {
      logic                  is_hit;
      logic                  evict_valid;
      logic [PAGE_BITS-1:0]  evicted_page;
      logic [COUNT_BITS-1:0] hit_total;
      logic [COUNT_BITS-1:0] miss_total;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type req;
   } item_type;

endpackage

`default_nettype wire

### src/lru_fe.sv
// front end: takes request transfers and queues them for the back end
// depends on lru_pkg and lru_page_replacement_defines.svh
`default_nettype none
`include "lru_page_replacement_defines.svh"

module lru_fe (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lru_pkg::req_type req_payload,
   output lru_pkg::item_type     item
);

   lru_pkg::req_type q_ff [lru_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign busy = (cnt_ff == 2'(lru_pkg::QUEUE_DEPTH));
   assign push = start && !busy;
   assign pop  = (cnt_ff != 2'd0);

   assign item.valid = pop;
   assign item.req   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_payload;
      end
   end

   `LRU_ASSERT(a_fe_cnt_bound, clock, reset, cnt_ff <= 2'(lru_pkg::QUEUE_DEPTH))
   `LRU_ASSERT(a_fe_drain, clock, reset, (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
   `LRU_ASSERT(a_fe_ptr_gap, clock, reset, (cnt_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule

`default_nettype wire

### src/lru_be.sv
// back end: recency list, hit and miss counters, result register
// depends on lru_pkg and lru_page_replacement_defines.svh
`default_nettype none
`include "lru_page_replacement_defines.svh"

module lru_be #(
   parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lru_pkg::CSR_BITS-1:0]  frames_in_use,
   input  wire lru_pkg::item_type             item,
   output logic                               rsp_valid,
   output lru_pkg::rsp_type                   rsp_payload
);

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W = (CNT_W > lru_pkg::CSR_BITS) ? CNT_W : lru_pkg::CSR_BITS;
   localparam int PB    = lru_pkg::PAGE_BITS;
   localparam int CB    = lru_pkg::COUNT_BITS;

   logic [PB-1:0]    list_ff [MAX_FRAMES];
   logic [PB-1:0]    list_in [MAX_FRAMES];
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CB-1:0]    hit_ff, hit_in;
   logic [CB-1:0]    miss_ff, miss_in;
   logic             rsp_valid_ff;
   lru_pkg::rsp_type rsp_ff, rsp_in;

   logic [LIM_W-1:0]      limit;
   logic [LIM_W-1:0]      occ;
   logic [CB-1:0]         hit_base, miss_base;
   logic [MAX_FRAMES-1:0] match, from_pos;
   logic                  hit, evict, do_shift;
   logic [PB-1:0]         page;

   always_comb begin
      limit = LIM_W'(frames_in_use);
      if (limit == '0) begin
         limit = LIM_W'(1);
      end
      if (limit > LIM_W'(MAX_FRAMES)) begin
         limit = LIM_W'(MAX_FRAMES);
      end

      page      = item.req.page_number;
      occ       = item.req.restart ? '0 : LIM_W'(occ_ff);
      hit_base  = item.req.restart ? '0 : hit_ff;
      miss_base = item.req.restart ? '0 : miss_ff;

      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = (LIM_W'(i) < occ) && (list_ff[i] == page);
      end
      hit = |match;
      from_pos[0] = match[0];
      for (int i = 1; i < MAX_FRAMES; i++) begin
         from_pos[i] = from_pos[i-1] | match[i];
      end

      evict    = !hit && (occ >= limit);
      do_shift = hit || evict;

      for (int i = 0; i < MAX_FRAMES; i++) begin
         list_in[i] = list_ff[i];
         if (do_shift) begin
            if (LIM_W'(i) + LIM_W'(1) == occ) begin
               list_in[i] = page;
            end else if ((!hit || from_pos[i]) && (LIM_W'(i) + LIM_W'(1) < occ)) begin
               list_in[i] = list_ff[(i + 1) % MAX_FRAMES];
            end
         end else if (LIM_W'(i) == occ) begin
            list_in[i] = page;
         end
      end

      occ_in  = do_shift ? CNT_W'(occ) : CNT_W'(occ + LIM_W'(1));
      hit_in  = hit_base;
      miss_in = miss_base;
      if (hit) begin
         hit_in = (hit_base == '1) ? hit_base : hit_base + CB'(1);
      end else begin
         miss_in = (miss_base == '1) ? miss_base : miss_base + CB'(1);
      end

      rsp_in.is_hit       = hit;
      rsp_in.evict_valid  = evict;
      rsp_in.evicted_page = evict ? list_ff[0] : '0;
      rsp_in.hit_total    = hit_in;
      rsp_in.miss_total   = miss_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= item.valid;
         if (item.valid) begin
            occ_ff  <= occ_in;
            hit_ff  <= hit_in;
            miss_ff <= miss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item.valid) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            list_ff[i] <= list_in[i];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `LRU_ASSERT(a_be_occ_bound, clock, reset, occ_ff <= CNT_W'(MAX_FRAMES))
   `LRU_ASSERT(a_be_result_follows, clock, reset, item.valid |=> rsp_valid_ff)
   `LRU_ASSERT(a_be_hit_no_evict, clock, reset, rsp_valid_ff |-> !(rsp_ff.is_hit && rsp_ff.evict_valid))
   `LRU_ASSERT(a_be_occ_nonzero, clock, reset, rsp_valid_ff |-> (occ_ff != '0))
   `LRU_ASSERT_ALWAYS(a_be_idle_after_reset, clock, (!reset && $past(reset)) |-> !rsp_valid_ff)

endmodule

`default_nettype wire

### src/lru_page_replacement.sv
// lru page replacement block: frame count register, request queue, recency list
// result path: the start transfer is held in the queue stage, then the result register raises the result strobe
// throughput: one reference per cycle, set by the combinational compare and shift of the list
// the result side cannot stall; busy stays low since the back end takes a queued transfer each cycle
// reset clears occupancy, both counters and the queue; frames_in_use returns to 8
// depends on lru_pkg, lru_fe, lru_be
`default_nettype none

module lru_page_replacement #(
   parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire lru_pkg::req_type             req_payload,
   output logic                              rsp_valid,
   output lru_pkg::rsp_type                  rsp_payload,
   input  wire logic                         csr_we,
   input  wire logic [lru_pkg::CSR_BITS-1:0] csr_wdata
);

   logic [lru_pkg::CSR_BITS-1:0] frames_ff, frames_in;
   lru_pkg::item_type            item;

   assign frames_in = csr_we ? csr_wdata : frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= lru_pkg::FRAMES_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   lru_fe u_fe (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .item        (item)
   );

   lru_be #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_be (
      .clock         (clock),
      .reset         (reset),
      .frames_in_use (frames_ff),
      .item          (item),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload)
   );

endmodule

`default_nettype wire
